>>> hdl/wdbs_pkg.sv
// Shared types and constants for the work_deque_bulk_steal block.
// Depends on nothing; used by wdbs_plan and work_deque_bulk_steal.
package wdbs_pkg;

  // default parameter values
  localparam int DEPTH_DEF     = 1024;
  localparam int NODE_BITS_DEF = 64;
  localparam int MAX_BURST_DEF = 64;

  // operation codes
  localparam logic [2:0] OP_PUSH       = 3'd0;
  localparam logic [2:0] OP_POP_BACK   = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_BULK_BACK  = 3'd3;
  localparam logic [2:0] OP_HALF_BACK  = 3'd4;
  localparam logic [2:0] OP_FRAC_FRONT = 3'd5;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_MIN_BATCH = 2'd0;
  localparam logic [1:0] CFG_MAX_BATCH = 2'd1;
  localparam logic [1:0] CFG_FRACTION  = 2'd2;

  // configuration reset values
  localparam logic [10:0] MIN_BATCH_RST = 11'd1;
  localparam logic [6:0]  MAX_BATCH_RST = 7'd64;
  localparam logic [8:0]  FRACTION_RST  = 9'd128;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [63:0] node_in;
  } in_t;

  typedef struct packed {
    logic [63:0] node_out;
    logic        has_node;
    logic [6:0]  taken_count;
    logic [1:0]  status;
    logic        last;
  } out_t;

  // decision for one operation
  typedef struct packed {
    logic [1:0] status;
    logic [6:0] take;
  } plan_t;

endpackage

>>> hdl/wdbs_plan.sv
// Operation decision: status and node count taken for one operation.
// Depends on wdbs_pkg (opcodes, status codes, plan_t).
module wdbs_plan #(
  parameter int DEPTH     = wdbs_pkg::DEPTH_DEF,
  parameter int MAX_BURST = wdbs_pkg::MAX_BURST_DEF,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic [2:0]      opcode,
  input  logic [CW-1:0]   count,
  input  logic [CW+8:0]   prod,
  input  logic [10:0]     min_batch,
  input  logic [6:0]      max_batch,
  output wdbs_pkg::plan_t plan
);

  localparam int EW = ((CW > 12) ? CW : 12) + 1;

  logic [EW-1:0] cnt_e, min_e, min2_e, maxb_e, burst_e, half_e, frac_e;
  logic [EW-1:0] bulk_e, half_take_e, frac_take_e;

  function automatic logic [EW-1:0] min2(input logic [EW-1:0] a, input logic [EW-1:0] b);
    min2 = (a < b) ? a : b;
  endfunction

  assign cnt_e       = EW'(count);
  assign min_e       = EW'(min_batch);
  assign min2_e      = EW'({min_batch, 1'b0});
  assign maxb_e      = EW'(max_batch);
  assign burst_e     = EW'(MAX_BURST);
  assign half_e      = cnt_e >> 1;
  assign frac_e      = EW'(prod >> 8);
  assign bulk_e      = min2(min2(cnt_e, maxb_e), burst_e);
  assign half_take_e = min2(half_e, burst_e);
  assign frac_take_e = min2(frac_e, burst_e);

  always_comb begin
    plan.status = wdbs_pkg::ST_EMPTY;
    plan.take   = 7'd0;
    unique case (opcode) inside
      wdbs_pkg::OP_PUSH: begin
        plan.status = (cnt_e == EW'(DEPTH)) ? wdbs_pkg::ST_FULL : wdbs_pkg::ST_OK;
      end
      wdbs_pkg::OP_POP_BACK, wdbs_pkg::OP_POP_FRONT: begin
        if (cnt_e != '0) begin
          plan.status = wdbs_pkg::ST_OK;
          plan.take   = 7'd1;
        end
      end
      wdbs_pkg::OP_BULK_BACK: begin
        if (cnt_e >= min_e) begin
          plan.status = wdbs_pkg::ST_OK;
          plan.take   = bulk_e[6:0];
        end
      end
      wdbs_pkg::OP_HALF_BACK: begin
        if (cnt_e >= min2_e) begin
          plan.status = wdbs_pkg::ST_OK;
          plan.take   = half_take_e[6:0];
        end
      end
      wdbs_pkg::OP_FRAC_FRONT: begin
        if (cnt_e >= min2_e) begin
          plan.status = wdbs_pkg::ST_OK;
          plan.take   = frac_take_e[6:0];
        end
      end
      default: begin
        plan.status = wdbs_pkg::ST_EMPTY;
      end
    endcase
  end

endmodule

>>> hdl/work_deque_bulk_steal.sv
// work_deque_bulk_steal: ring-buffer deque of tree nodes with bulk steal.
// Depends on wdbs_pkg and wdbs_plan.
// An accepted operation goes from S_PLAN to S_OUT when no node is removed, else
// through S_RD and S_OUT once per node (address, then data on the one read port);
// a stalled result holds the sequencer, and in_ready is high only in S_IDLE.
// Reset (rst_n low, synchronous): deque empty, head at 0, registers to defaults.
module work_deque_bulk_steal #(
  parameter int DEPTH     = wdbs_pkg::DEPTH_DEF,
  parameter int NODE_BITS = wdbs_pkg::NODE_BITS_DEF,
  parameter int MAX_BURST = wdbs_pkg::MAX_BURST_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  // input transactions
  input  logic           in_valid,
  output logic           in_ready,
  input  wdbs_pkg::in_t  in_data,
  // result transactions
  output logic           out_valid,
  input  logic           out_ready,
  output wdbs_pkg::out_t out_data,
  // configuration writes
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [1:0]     cfg_index,
  input  logic [10:0]    cfg_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;  // waiting for a transaction
  localparam logic [1:0] S_PLAN = 2'd1;  // decide, update pointers, push write
  localparam logic [1:0] S_RD   = 2'd2;  // issue store read of one node
  localparam logic [1:0] S_OUT  = 2'd3;  // hand one result to the output reg

  logic [1:0]  state_r, state_nxt;

  // configuration registers
  logic [10:0] min_batch_r;
  logic [6:0]  max_batch_r;
  logic [8:0]  fraction_r;
  logic [8:0]  frac_clamped;

  // deque pointers
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;

  // current operation
  logic [2:0]           op_r;
  logic [NODE_BITS-1:0] node_r;
  logic [CW+8:0]        prod_r;
  logic [6:0]           take_r, take_nxt;
  logic [1:0]           status_r, status_nxt;
  logic [6:0]           idx_r, idx_nxt;
  logic [AW-1:0]        slot_r, slot_nxt;

  wdbs_pkg::plan_t plan;

  // node store
  logic [NODE_BITS-1:0] mem [DEPTH];
  logic [NODE_BITS-1:0] rdata_r;
  logic                 mem_we;
  logic [AW-1:0]        wr_addr;

  // output register
  logic           out_valid_r, out_valid_nxt;
  wdbs_pkg::out_t out_r, out_nxt;
  logic           out_free, out_load, is_last;

  logic [CW-1:0] offset;
  logic          from_back;

  function automatic logic [AW-1:0] wrap(input logic [AW:0] s);
    wrap = (s >= (AW + 1)'(DEPTH)) ? AW'(s - (AW + 1)'(DEPTH)) : AW'(s);
  endfunction

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign frac_clamped = (fraction_r > 9'd256) ? 9'd256 : fraction_r;

  wdbs_plan #(
    .DEPTH     (DEPTH),
    .MAX_BURST (MAX_BURST)
  ) u_plan (
    .opcode    (op_r),
    .count     (count_r),
    .prod      (prod_r),
    .min_batch (min_batch_r),
    .max_batch (max_batch_r),
    .plan      (plan)
  );

  // configuration writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_batch_r <= wdbs_pkg::MIN_BATCH_RST;
      max_batch_r <= wdbs_pkg::MAX_BATCH_RST;
      fraction_r  <= wdbs_pkg::FRACTION_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        wdbs_pkg::CFG_MIN_BATCH: min_batch_r <= cfg_data;
        wdbs_pkg::CFG_MAX_BATCH: max_batch_r <= cfg_data[6:0];
        wdbs_pkg::CFG_FRACTION:  fraction_r  <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Store offset of the first node touched: back removals start at count-take,
  // a push lands at count, front removals start at the head.
  assign from_back = (op_r == wdbs_pkg::OP_POP_BACK) || (op_r == wdbs_pkg::OP_BULK_BACK)
                  || (op_r == wdbs_pkg::OP_HALF_BACK);
  always_comb begin
    if (op_r == wdbs_pkg::OP_PUSH) begin
      offset = count_r;
    end else if (from_back) begin
      offset = count_r - CW'(plan.take);
    end else begin
      offset = '0;
    end
  end

  assign out_free = !out_valid_r || out_ready;
  assign is_last  = (take_r == 7'd0) || (idx_r + 7'd1 == take_r);

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    take_nxt      = take_r;
    status_nxt    = status_r;
    idx_nxt       = idx_r;
    slot_nxt      = slot_r;
    mem_we        = 1'b0;
    wr_addr       = wrap((AW + 1)'(head_r) + (AW + 1)'(count_r));
    out_load      = 1'b0;
    out_nxt       = out_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_PLAN;
        end
      end
      S_PLAN: begin
        take_nxt   = plan.take;
        status_nxt = plan.status;
        idx_nxt    = 7'd0;
        slot_nxt   = wrap((AW + 1)'(head_r) + (AW + 1)'(offset));
        if (op_r == wdbs_pkg::OP_PUSH && plan.status == wdbs_pkg::ST_OK) begin
          mem_we    = 1'b1;
          count_nxt = count_r + CW'(1);
        end
        if (plan.take != 7'd0) begin
          count_nxt = count_r - CW'(plan.take);
          if (op_r == wdbs_pkg::OP_POP_FRONT || op_r == wdbs_pkg::OP_FRAC_FRONT) begin
            head_nxt = wrap((AW + 1)'(head_r) + (AW + 1)'(plan.take));
          end
          state_nxt = S_RD;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_RD: begin
        slot_nxt  = wrap((AW + 1)'(slot_r) + (AW + 1)'(1));
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_load            = 1'b1;
          out_nxt.has_node    = (take_r != 7'd0);
          out_nxt.node_out    = (take_r != 7'd0) ? 64'(rdata_r) : 64'd0;
          out_nxt.taken_count = take_r;
          out_nxt.status      = status_r;
          out_nxt.last        = is_last;
          idx_nxt             = idx_r + 7'd1;
          state_nxt           = is_last ? S_IDLE : S_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // operation payload; fraction product taken at accept, count is stable then
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r   <= in_data.opcode;
      node_r <= in_data.node_in[NODE_BITS-1:0];
      prod_r <= (CW + 9)'(count_r) * (CW + 9)'(frac_clamped);
    end
    take_r   <= take_nxt;
    status_r <= status_nxt;
    idx_r    <= idx_nxt;
    slot_r   <= slot_nxt;
    out_r    <= out_nxt;
  end

  // node store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= node_r;
    end
    if (state_r == S_RD) begin
      rdata_r <= mem[slot_r];
    end
  end

endmodule
